// File: rtl/core/lbit_pkg.sv
`timescale 1ns / 1ps
// Package for the line versus box intersection test.
// Holds the default widths, the register map and shared types; no dependencies.
package lbit_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int THRESH_WIDTH = 16;
	localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 16'd7;
	localparam int NUM_REGS = 1;
	localparam int PADDR_WIDTH = 1;
	localparam logic [PADDR_WIDTH-1:0] REG_PARALLEL_THRESHOLD = 1'b0;

	typedef struct packed {
		logic valid;
		logic stall;
	} pipe_ctrl_t;
endpackage

// File: rtl/core/lbit_if.sv
`timescale 1ns / 1ps
// Channel interfaces for the line versus box test: input item and result.
// Depends on nothing; widths come from parameters.
interface lbit_in_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic signed [CW-1:0] box_min_x, box_min_y, box_min_z;
	logic signed [CW-1:0] box_max_x, box_max_y, box_max_z;
	logic signed [CW-1:0] origin_x, origin_y, origin_z;
	logic signed [CW-1:0] dir_x, dir_y, dir_z;
	modport source(output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, input ready);
	modport sink(input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface lbit_out_if;
	logic valid;
	logic ready;
	logic hit;
	modport source(output valid, hit, input ready);
	modport sink(input valid, hit, output ready);
endinterface

// File: rtl/core/lbit_face.sv
`timescale 1ns / 1ps
// One face test: long division for the line parameter, then two saturating
// products and range checks. Pipelined, one item per cycle while en is high. Uses lbit_pkg.
module lbit_face import lbit_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF,
	parameter int FB = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic signed [CW-1:0] plane,
	input  logic signed [CW-1:0] oa,
	input  logic signed [CW-1:0] da,
	input  logic signed [CW-1:0] db,
	input  logic signed [CW-1:0] dc,
	input  logic signed [CW-1:0] ob,
	input  logic signed [CW-1:0] oc,
	input  logic signed [CW-1:0] bmin_b,
	input  logic signed [CW-1:0] bmax_b,
	input  logic signed [CW-1:0] bmin_c,
	input  logic signed [CW-1:0] bmax_c,
	output logic face_hit
);
	localparam int NW = CW + 1 + FB;
	localparam int QB = NW;
	localparam int PW = NW + CW;
	localparam int DS = QB + 1;

	typedef struct packed {
		logic signed [CW-1:0] db, dc, ob, oc, bmin_b, bmax_b, bmin_c, bmax_c;
	} side_t;

	side_t side_s [DS+1];
	logic [NW-1:0] rem_s [DS+1];
	logic [NW-1:0] num_s [DS+1];
	logic [QB-1:0] quo_s [DS+1];
	logic [CW-1:0] den_s [DS+1];
	logic qneg_s [DS+1];

	logic signed [CW:0] off;
	assign off = {plane[CW-1], plane} - {oa[CW-1], oa};

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= '{db, dc, ob, oc, bmin_b, bmax_b, bmin_c, bmax_c};
			num_s[0] <= NW'(off[CW] ? -off : off) << FB;
			den_s[0] <= da[CW-1] ? -da : da;
			qneg_s[0] <= off[CW] != da[CW-1];
			rem_s[0] <= '0;
			quo_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < DS; i++) begin : g_div
		logic [NW:0] trial;
		always_comb trial = {rem_s[i], num_s[i][NW-1]} - (NW+1)'(den_s[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				den_s[i+1] <= den_s[i];
				qneg_s[i+1] <= qneg_s[i];
				num_s[i+1] <= num_s[i] << 1;
				if (i == DS-1) begin
					rem_s[i+1] <= rem_s[i];
					quo_s[i+1] <= quo_s[i];
				end else if (!trial[NW]) begin
					rem_s[i+1] <= trial[NW-1:0];
					quo_s[i+1] <= {quo_s[i][QB-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= {rem_s[i][NW-2:0], num_s[i][NW-1]};
					quo_s[i+1] <= {quo_s[i][QB-2:0], 1'b0};
				end
			end
		end
	end

	localparam logic [CW-1:0] HALF = {1'b1, {(CW-1){1'b0}}};
	logic [CW-1:0] qlim, q_s1;
	logic qneg_m1;
	side_t side_m1;
	assign qlim = qneg_s[DS] ? HALF : HALF - 1'b1;
	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= (quo_s[DS] > QB'(qlim)) ? qlim : quo_s[DS][CW-1:0];
			qneg_m1 <= qneg_s[DS];
			side_m1 <= side_s[DS];
		end
	end

	logic [2*CW-1:0] pb_s2, pc_s2;
	logic nb_s2, nc_s2;
	side_t side_m2;
	logic [CW-1:0] mb, mc;
	assign mb = side_m1.db[CW-1] ? -side_m1.db : side_m1.db;
	assign mc = side_m1.dc[CW-1] ? -side_m1.dc : side_m1.dc;
	always_ff @(posedge clk) begin
		if (en) begin
			pb_s2 <= q_s1 * mb;
			pc_s2 <= q_s1 * mc;
			nb_s2 <= qneg_m1 != side_m1.db[CW-1];
			nc_s2 <= qneg_m1 != side_m1.dc[CW-1];
			side_m2 <= side_m1;
		end
	end

	function automatic logic [CW-1:0] sat_shift(input logic [2*CW-1:0] p, input logic neg);
		logic [2*CW-1:0] s;
		logic [CW-1:0] lim;
		s = p >> FB;
		lim = neg ? HALF : HALF - 1'b1;
		return (s > (2*CW)'(lim)) ? lim : s[CW-1:0];
	endfunction

	logic signed [CW+1:0] vb_s3, vc_s3;
	side_t side_m3;
	logic [CW-1:0] sb, sc;
	assign sb = sat_shift(pb_s2, nb_s2);
	assign sc = sat_shift(pc_s2, nc_s2);
	always_ff @(posedge clk) begin
		if (en) begin
			vb_s3 <= nb_s2 ? (CW+2)'(side_m2.ob) - (CW+2)'({1'b0, sb})
				: (CW+2)'(side_m2.ob) + (CW+2)'({1'b0, sb});
			vc_s3 <= nc_s2 ? (CW+2)'(side_m2.oc) - (CW+2)'({1'b0, sc})
				: (CW+2)'(side_m2.oc) + (CW+2)'({1'b0, sc});
			side_m3 <= side_m2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_hit <= 1'b0;
		end else if (en) begin
			face_hit <= vb_s3 >= (CW+2)'(side_m3.bmin_b) && vb_s3 <= (CW+2)'(side_m3.bmax_b)
				&& vc_s3 >= (CW+2)'(side_m3.bmin_c) && vc_s3 <= (CW+2)'(side_m3.bmax_c);
		end
	end
endmodule

// File: rtl/core/line_box_intersection_test.sv
`timescale 1ns / 1ps
// Line versus axis-aligned box intersection test, top level.
// Depends on lbit_pkg, lbit_if and lbit_face.
//
// Usage: items arrive on the in channel (box corners, line origin and
// direction, signed fixed point) and one hit bit per item leaves on the out
// channel. A transfer happens when valid and ready are both high.
// The pipeline takes one item per cycle while the receiver does not stall. Its
// depth is mostly set by the bit-per-stage divider in each face unit.
// Six face units run in parallel. When the receiver stalls, the whole pipeline
// holds and in.ready falls, so nothing is lost or repeated.
// The APB register parallel_threshold sits at address 0, reset value 7.
// Reset clears all valid bits and loads the register reset value.
module line_box_intersection_test import lbit_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	lbit_in_if.sink in_ch,
	lbit_out_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_WIDTH+1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int CW = COORD_WIDTH;
	localparam int LAT = CW + 1 + FRAC_BITS + 1 + 5;

	logic [THRESH_WIDTH-1:0] thresh_q;
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_WIDTH+1:2] == REG_PARALLEL_THRESHOLD && paddr[1:0] == 2'b00)
		? 32'(thresh_q) : '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00
			&& paddr[PADDR_WIDTH+1:2] == REG_PARALLEL_THRESHOLD) begin
			thresh_q <= pwdata[THRESH_WIDTH-1:0];
		end
	end

	pipe_ctrl_t ctl;
	logic en;
	logic [LAT-1:0] vld_q;
	assign ctl.valid = vld_q[LAT-1];
	assign ctl.stall = ctl.valid && !out_ch.ready;
	assign en = !ctl.stall;
	assign in_ch.ready = en;
	assign out_ch.valid = ctl.valid;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_ch.valid};
	end

	logic signed [CW-1:0] bmin [3], bmax [3], org [3], dir [3];
	assign bmin = '{in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z};
	assign bmax = '{in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z};
	assign org = '{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z};
	assign dir = '{in_ch.dir_x, in_ch.dir_y, in_ch.dir_z};

	logic [5:0] fh;
	logic [2:0] live_c;
	logic [2:0] live_s1;
	logic [2:0] live_d [LAT-1];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic [CW-1:0] dm;
		assign dm = dir[a][CW-1] ? -dir[a] : dir[a];
		assign live_c[a] = dm != '0 && !(dm < CW'(thresh_q));
		for (genvar f = 0; f < 2; f++) begin : g_face
			lbit_face #(.CW(CW), .FB(FRAC_BITS)) u_face (
				.clk(clk), .arst_n(arst_n), .en(en),
				.plane(f == 0 ? bmax[a] : bmin[a]), .oa(org[a]), .da(dir[a]),
				.db(dir[(a+1)%3]), .dc(dir[(a+2)%3]),
				.ob(org[(a+1)%3]), .oc(org[(a+2)%3]),
				.bmin_b(bmin[(a+1)%3]), .bmax_b(bmax[(a+1)%3]),
				.bmin_c(bmin[(a+2)%3]), .bmax_c(bmax[(a+2)%3]),
				.face_hit(fh[2*a+f])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) live_s1 <= live_c;
	end

	for (genvar i = 0; i < LAT-1; i++) begin : g_live
		always_ff @(posedge clk) begin
			if (en) live_d[i] <= (i == 0) ? live_s1 : live_d[i-(i>0)];
		end
	end

	logic [2:0] lv;
	assign lv = live_d[LAT-2];
	assign out_ch.hit = (lv[0] && (fh[0] || fh[1])) || (lv[1] && (fh[2] || fh[3]))
		|| (lv[2] && (fh[4] || fh[5]));

`ifndef SYNTH
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.stall |=> out_ch.valid) else $error("result dropped during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == !(out_ch.valid && !out_ch.ready)) else $error("ready mismatch");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !vld_q[LAT-2]) |=> !out_ch.valid) else $error("spurious result");
`endif
endmodule
